/* rtl/core/buddy_frame_allocator_unit_macros.svh */
// Assertion macros shared by the buddy frame allocator RTL.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef BUDDY_FRAME_ALLOCATOR_UNIT_MACROS_SVH
`define BUDDY_FRAME_ALLOCATOR_UNIT_MACROS_SVH

// Consequence must hold in the same cycle as the antecedent.
`define BFA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bfa_pkg.sv */
// Package for the buddy frame allocator: sizes, codes, types and helpers.
// Used by bfa_engine and buddy_frame_allocator_unit; depends on nothing.
package bfa_pkg;

    localparam int FRAMES    = 4096;
    localparam int TOP_ORDER = 12;
    localparam int ADDR_W    = $clog2(FRAMES);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int ORD_W     = $clog2(TOP_ORDER + 2);
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;

    typedef enum logic [1:0] {FS_FREE, FS_ALLOC, FS_RES, FS_ABSENT} t_fstat;
    typedef enum logic [1:0] {OP_ALLOC, OP_FREE, OP_RESERVE, OP_NONE} t_op;
    typedef enum logic [STAT_W-1:0] {RS_OK, RS_TOO_LARGE, RS_NO_MEM, RS_NOT_FOUND} t_rstat;

    typedef enum logic [4:0] {
        S_POP, S_IDLE, S_DISP, S_SCAN, S_SPLIT, S_CCHK, S_CFIND, S_CFWAIT,
        S_CSPLIT, S_CSPLIT2, S_CMARK, S_FPIECE, S_FMERGE, S_FMWAIT, S_FFILL, S_DONE
    } t_state;

    typedef struct packed {
        t_fstat            st;
        logic [ORD_W-1:0]  ord;
        logic              head;
    } t_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_word             wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    typedef struct packed {
        logic              vld;
        logic [ADDR_W-1:0] start;
        t_rstat            status;
    } t_result;

    function automatic logic [CNT_W-1:0] pw(input logic [ORD_W-1:0] o);
        return CNT_W'(1) << o;
    endfunction

    function automatic t_word mk_word(input t_fstat st, input logic [ORD_W-1:0] o,
                                      input logic head);
        t_word w;
        w.st   = st;
        w.ord  = o;
        w.head = head;
        return w;
    endfunction

    // Initial layout: a frame below total lies in the block whose order is
    // the highest bit where the frame number and total differ.
    function automatic t_word pop_word(input logic [ADDR_W-1:0] idx,
                                       input logic [CNT_W-1:0] total);
        logic [CNT_W-1:0] x;
        logic [ORD_W-1:0] o;
        t_word            w;
        x = {1'b0, idx} ^ total;
        o = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (x[b]) begin
                o = ORD_W'(b);
            end
        end
        w = mk_word(FS_FREE, o, (({1'b0, idx} & (pw(o) - CNT_W'(1))) == '0));
        if ({1'b0, idx} >= total) begin
            w = mk_word(FS_ABSENT, '0, 1'b0);
        end
        return w;
    endfunction

    // Smallest order whose block holds n frames.
    function automatic logic [ORD_W-1:0] ceil_ord(input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] o;
        o = '0;
        for (int b = 0; b <= TOP_ORDER; b++) begin
            if (pw(ORD_W'(b)) < n) begin
                o = ORD_W'(b + 1);
            end
        end
        return o;
    endfunction

    // Largest aligned block at s, no larger than n and the top order.
    function automatic logic [ORD_W-1:0] piece_ord(input logic [ADDR_W-1:0] s,
                                                   input logic [CNT_W-1:0] n);
        logic [ORD_W-1:0] tz;
        logic [ORD_W-1:0] fl;
        tz = ORD_W'(TOP_ORDER);
        for (int b = ADDR_W - 1; b >= 0; b--) begin
            if (s[b]) begin
                tz = ORD_W'(b);
            end
        end
        fl = '0;
        for (int b = 0; b < CNT_W; b++) begin
            if (n[b]) begin
                fl = ORD_W'(b);
            end
        end
        if (fl > ORD_W'(TOP_ORDER)) begin
            fl = ORD_W'(TOP_ORDER);
        end
        return (tz < fl) ? tz : fl;
    endfunction

endpackage

/* rtl/core/buddy_frame_allocator_unit.sv */
// Buddy frame allocator over a store of 4096 frames, with its result register.
// Depends on bfa_pkg, bfa_engine, bfa_ram and the assertion macro header.
//
// Use: one request beat on the input channel (operation, frame_number,
// frame_count) gives exactly one result beat (start_frame, status). Requests
// are handled one at a time; o_ready is high only while the sequencer is idle.
// Most steps go through the frame store, one access per cycle:
//   allocate: a scan of the block heads, a write per split of the chosen
//     block, then for each piece a look-up of its block, the splits while
//     carving and the marking of its frames.
//   free: a check of every frame in the range, then for each aligned piece
//     the buddy look-ups and merges and a rewrite of the merged block.
//   reserve: the same check, then look-up, splits and marking.
// Requests with a zero count or a bad code finish without touching the store.
// The result sits in an output register; a new request is taken while an
// earlier result waits, and a stalled receiver only holds the next result.
// After reset, and after each write of total_frames, a pass over all 4096
// frames rebuilds the store; no request is taken during it.
`include "buddy_frame_allocator_unit_macros.svh"
module buddy_frame_allocator_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bfa_pkg::OP_W-1:0]    i_operation,
    input  logic [bfa_pkg::ADDR_W-1:0]  i_frame_number,
    input  logic [bfa_pkg::CNT_W-1:0]   i_frame_count,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bfa_pkg::ADDR_W-1:0]  o_start_frame,
    output logic [bfa_pkg::STAT_W-1:0]  o_status
);
    import bfa_pkg::*;

    t_result              w_res;
    t_ram_req             w_req;
    t_word                w_word;
    logic [$bits(t_word)-1:0] w_rdata;
    logic                 w_slot_free;

    logic                 r_out_vld;
    logic [ADDR_W-1:0]    r_out_start;
    logic [STAT_W-1:0]    r_out_status;

    // The result register is free when empty or being emptied this cycle.
    assign w_slot_free = !r_out_vld || i_ready;

    bfa_engine u_engine (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_operation    (i_operation),
        .i_frame_number (i_frame_number),
        .i_frame_count  (i_frame_count),
        .i_slot_free    (w_slot_free),
        .o_result       (w_res),
        .o_ram_req      (w_req),
        .i_ram_rdata    (w_word)
    );

    // Frame store: status, block order and free-head mark of every frame.
    bfa_ram #(
        .WIDTH ($bits(t_word)),
        .DEPTH (FRAMES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_req.we),
        .i_waddr (w_req.waddr),
        .i_wdata (w_req.wdata),
        .i_raddr (w_req.raddr),
        .o_rdata (w_rdata)
    );

    assign w_word = t_word'(w_rdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_slot_free) begin
            r_out_vld <= w_res.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free && w_res.vld) begin
            r_out_start  <= w_res.start;
            r_out_status <= w_res.status;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_start_frame = r_out_start;
    assign o_status      = r_out_status;

    // A taken request keeps the sequencer busy in the following cycle.
    `BFA_ASSERT_NEXT(a_busy_after_beat, i_valid && o_ready, !o_ready, "ready after accepted beat")
    // A configuration write always starts a rebuild of the store.
    `BFA_ASSERT_NEXT(a_cfg_rebuild, i_cfg_we, !o_ready, "no rebuild after config write")
    // The store is never written while the sequencer waits for a request.
    `BFA_ASSERT_SAME(a_no_idle_write, w_req.we, !o_ready, "store written while idle")
    // Only a successful allocate reports a non-zero start frame.
    `BFA_ASSERT_SAME(a_start_zero, o_valid && o_status != RS_OK, o_start_frame == '0,
                     "start frame set on failed request")
endmodule

/* rtl/core/bfa_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the frame store.
module bfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/core/bfa_engine.sv */
// Request sequencer of the buddy frame allocator: scans, splits, carves,
// merges and rebuilds the frame store one access per cycle. Uses bfa_pkg.
module bfa_engine (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::CNT_W-1:0]   i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bfa_pkg::OP_W-1:0]    i_operation,
    input  logic [bfa_pkg::ADDR_W-1:0]  i_frame_number,
    input  logic [bfa_pkg::CNT_W-1:0]   i_frame_count,
    input  logic                        i_slot_free,
    output bfa_pkg::t_result            o_result,
    output bfa_pkg::t_ram_req           o_ram_req,
    input  bfa_pkg::t_word              i_ram_rdata
);
    import bfa_pkg::*;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_total, n_total;
    logic [ADDR_W-1:0]  r_pop_i, n_pop_i;
    t_op                r_op, n_op;
    logic [CNT_W-1:0]   r_s, n_s;
    logic [CNT_W-1:0]   r_n, n_n;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [CNT_W-1:0]   r_lim, n_lim;
    logic               r_rv, n_rv;
    logic [ADDR_W-1:0]  r_ra, n_ra;
    logic               r_fail, n_fail;
    logic [ORD_W-1:0]   r_k, n_k;
    logic               r_best_vld, n_best_vld;
    logic [ORD_W-1:0]   r_best_ord, n_best_ord;
    logic [ADDR_W-1:0]  r_best_pos, n_best_pos;
    logic [ADDR_W-1:0]  r_h, n_h;
    logic [ADDR_W-1:0]  r_p, n_p;
    logic [ADDR_W-1:0]  r_b, n_b;
    logic [ADDR_W-1:0]  r_mid, n_mid;
    logic [ORD_W-1:0]   r_o, n_o;
    logic [ORD_W-1:0]   r_fk, n_fk;
    logic [ORD_W-1:0]   r_j, n_j;
    t_fstat             r_st, n_st;
    logic [ADDR_W-1:0]  r_start, n_start;
    t_rstat             r_status, n_status;

    logic [CNT_W-1:0]   w_pw_o, w_pw_j, w_pw_dec, w_pw_fk;
    logic [ORD_W-1:0]   w_o_dec;
    logic               w_issue, w_scan_end, w_split_go, w_blk_last;
    logic [ADDR_W-1:0]  w_buddy, w_scan_addr, w_find_addr;
    logic               w_buddy_out, w_hit_fk, w_hit_o, w_range_bad, w_too_large;
    logic [CNT_W:0]     w_range_end;
    logic               w_pop_last, w_merge_more;
    t_ram_req           w_req;

    assign w_pw_o       = pw(r_o);
    assign w_pw_j       = pw(r_j);
    assign w_o_dec      = r_o - ORD_W'(1);
    assign w_pw_dec     = pw(w_o_dec);
    assign w_pw_fk      = pw(r_fk);
    assign w_issue      = (r_cnt != r_lim);
    assign w_scan_end   = !w_issue && !r_rv;
    assign w_split_go   = ((r_h != r_s[ADDR_W-1:0]) || (w_pw_o > r_n)) && (r_o != '0);
    assign w_blk_last   = (r_cnt == w_pw_o - CNT_W'(1));
    assign w_buddy      = r_p ^ w_pw_o[ADDR_W-1:0];
    assign w_buddy_out  = ({1'b0, w_buddy} >= r_total);
    assign w_merge_more = (r_o < ORD_W'(TOP_ORDER)) && !w_buddy_out;
    assign w_hit_fk     = i_ram_rdata.head && (i_ram_rdata.ord == r_fk);
    assign w_hit_o      = i_ram_rdata.head && (i_ram_rdata.ord == r_o);
    assign w_range_end  = {1'b0, r_s} + {1'b0, r_n};
    assign w_range_bad  = (w_range_end > {1'b0, r_total});
    assign w_too_large  = (r_n > CNT_W'(FRAMES));
    assign w_pop_last   = (r_pop_i == '1);
    assign w_scan_addr  = r_s[ADDR_W-1:0] + r_cnt[ADDR_W-1:0];
    assign w_find_addr  = r_s[ADDR_W-1:0] & ~(w_pw_fk[ADDR_W-1:0] - ADDR_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_POP: begin
                if (w_pop_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) n_state = S_DISP;
            end
            S_DISP: begin
                case (r_op)
                    OP_ALLOC: begin
                        n_state = (r_n == '0 || w_too_large) ? S_DONE : S_SCAN;
                    end
                    OP_FREE, OP_RESERVE: begin
                        n_state = (r_n == '0 || w_range_bad) ? S_DONE : S_SCAN;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (w_scan_end) begin
                    case (r_op)
                        OP_ALLOC: n_state = r_best_vld ? S_SPLIT : S_DONE;
                        OP_FREE:  n_state = r_fail ? S_DONE : S_FPIECE;
                        default:  n_state = r_fail ? S_DONE : S_CCHK;
                    endcase
                end
            end
            S_SPLIT: begin
                if (r_o == r_k) n_state = S_CCHK;
            end
            S_CCHK:    n_state = (r_n == '0) ? S_DONE : S_CFIND;
            S_CFIND:   n_state = S_CFWAIT;
            S_CFWAIT: begin
                if (w_hit_fk) begin
                    n_state = S_CSPLIT;
                end else if (r_fk == ORD_W'(TOP_ORDER)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CFIND;
                end
            end
            S_CSPLIT:  n_state = w_split_go ? S_CSPLIT2 : S_CMARK;
            S_CSPLIT2: n_state = S_CSPLIT;
            S_CMARK: begin
                if (w_blk_last) n_state = S_CCHK;
            end
            S_FPIECE:  n_state = (r_n == '0) ? S_DONE : S_FMERGE;
            S_FMERGE:  n_state = w_merge_more ? S_FMWAIT : S_FFILL;
            S_FMWAIT:  n_state = w_hit_o ? S_FMERGE : S_FFILL;
            S_FFILL: begin
                if (w_blk_last) n_state = S_FPIECE;
            end
            S_DONE: begin
                if (i_slot_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_we) n_state = S_POP;
    end

    // Datapath and memory requests.
    always_comb begin
        n_total    = r_total;
        n_pop_i    = r_pop_i;
        n_op       = r_op;
        n_s        = r_s;
        n_n        = r_n;
        n_cnt      = r_cnt;
        n_lim      = r_lim;
        n_rv       = r_rv;
        n_ra       = r_ra;
        n_fail     = r_fail;
        n_k        = r_k;
        n_best_vld = r_best_vld;
        n_best_ord = r_best_ord;
        n_best_pos = r_best_pos;
        n_h        = r_h;
        n_p        = r_p;
        n_b        = r_b;
        n_mid      = r_mid;
        n_o        = r_o;
        n_fk       = r_fk;
        n_j        = r_j;
        n_st       = r_st;
        n_start    = r_start;
        n_status   = r_status;
        w_req      = '0;
        case (r_state)
            S_POP: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_pop_i;
                w_req.wdata = pop_word(r_pop_i, r_total);
                n_pop_i     = r_pop_i + ADDR_W'(1);
            end
            S_IDLE: begin
                n_op = t_op'(i_operation);
                n_s  = {1'b0, i_frame_number};
                n_n  = i_frame_count;
            end
            S_DISP: begin
                n_status   = RS_OK;
                n_start    = '0;
                n_cnt      = '0;
                n_rv       = 1'b0;
                n_fail     = 1'b0;
                n_best_vld = 1'b0;
                n_k        = ceil_ord(r_n);
                n_lim      = r_n;
                n_st       = FS_RES;
                case (r_op)
                    OP_ALLOC: begin
                        n_s   = '0;
                        n_lim = r_total;
                        n_st  = FS_ALLOC;
                        if (r_n != '0 && w_too_large) n_status = RS_TOO_LARGE;
                    end
                    OP_FREE, OP_RESERVE: begin
                        if (r_n != '0 && w_range_bad) n_status = RS_NOT_FOUND;
                    end
                    default: n_status = RS_OK;
                endcase
            end
            S_SCAN: begin
                w_req.raddr = w_scan_addr;
                n_ra        = w_scan_addr;
                n_rv        = w_issue;
                if (w_issue) n_cnt = r_cnt + CNT_W'(1);
                if (r_rv) begin
                    case (r_op)
                        OP_ALLOC: begin
                            if (i_ram_rdata.head && i_ram_rdata.ord >= r_k &&
                                (!r_best_vld || i_ram_rdata.ord < r_best_ord)) begin
                                n_best_vld = 1'b1;
                                n_best_ord = i_ram_rdata.ord;
                                n_best_pos = r_ra;
                            end
                        end
                        OP_FREE: begin
                            if (i_ram_rdata.st == FS_FREE) n_fail = 1'b1;
                        end
                        default: begin
                            if (i_ram_rdata.st != FS_FREE) n_fail = 1'b1;
                        end
                    endcase
                end
                if (w_scan_end) begin
                    if (r_op == OP_ALLOC) begin
                        if (r_best_vld) begin
                            n_p     = r_best_pos;
                            n_o     = r_best_ord;
                            n_start = r_best_pos;
                            n_s     = {1'b0, r_best_pos};
                        end else begin
                            n_status = RS_NO_MEM;
                        end
                    end else if (r_fail) begin
                        n_status = RS_NOT_FOUND;
                    end
                end
            end
            S_SPLIT: begin
                w_req.we = 1'b1;
                if (r_o != r_k) begin
                    w_req.waddr = r_p + w_pw_dec[ADDR_W-1:0];
                    w_req.wdata = mk_word(FS_FREE, w_o_dec, 1'b1);
                    n_o         = w_o_dec;
                end else begin
                    w_req.waddr = r_p;
                    w_req.wdata = mk_word(FS_FREE, r_k, 1'b1);
                end
            end
            S_CCHK: begin
                n_fk = '0;
            end
            S_CFIND: begin
                w_req.raddr = w_find_addr;
                n_b         = w_find_addr;
            end
            S_CFWAIT: begin
                if (w_hit_fk) begin
                    n_h = r_b;
                    n_o = r_fk;
                end else begin
                    n_fk = r_fk + ORD_W'(1);
                end
            end
            S_CSPLIT: begin
                n_cnt = '0;
                if (w_split_go) begin
                    w_req.we    = 1'b1;
                    w_req.waddr = r_h + w_pw_dec[ADDR_W-1:0];
                    w_req.wdata = mk_word(FS_FREE, w_o_dec, 1'b1);
                    n_o         = w_o_dec;
                    n_mid       = r_h + w_pw_dec[ADDR_W-1:0];
                end
            end
            S_CSPLIT2: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_h;
                w_req.wdata = mk_word(FS_FREE, r_o, 1'b1);
                if (r_s >= {1'b0, r_mid}) n_h = r_mid;
            end
            S_CMARK: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_h + r_cnt[ADDR_W-1:0];
                w_req.wdata = mk_word(r_st, '0, 1'b0);
                n_cnt       = r_cnt + CNT_W'(1);
                if (w_blk_last) begin
                    n_s = r_s + w_pw_o;
                    n_n = (w_pw_o >= r_n) ? '0 : r_n - w_pw_o;
                end
            end
            S_FPIECE: begin
                n_j   = piece_ord(r_s[ADDR_W-1:0], r_n);
                n_o   = piece_ord(r_s[ADDR_W-1:0], r_n);
                n_p   = r_s[ADDR_W-1:0];
                n_cnt = '0;
            end
            S_FMERGE: begin
                w_req.raddr = w_buddy;
                n_cnt       = '0;
            end
            S_FMWAIT: begin
                if (w_hit_o) begin
                    n_p = r_p & ~w_pw_o[ADDR_W-1:0];
                    n_o = r_o + ORD_W'(1);
                end
            end
            S_FFILL: begin
                w_req.we    = 1'b1;
                w_req.waddr = r_p + r_cnt[ADDR_W-1:0];
                w_req.wdata = (r_cnt == '0) ? mk_word(FS_FREE, r_o, 1'b1)
                                            : mk_word(FS_FREE, '0, 1'b0);
                n_cnt       = r_cnt + CNT_W'(1);
                if (w_blk_last) begin
                    n_s = r_s + w_pw_j;
                    n_n = r_n - w_pw_j;
                end
            end
            S_DONE: begin
                n_cnt = r_cnt;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
        if (i_cfg_we) begin
            n_total = (i_cfg_data > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : i_cfg_data;
            n_pop_i = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_POP;
            r_total <= CNT_W'(FRAMES);
            r_pop_i <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_pop_i <= n_pop_i;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_s        <= n_s;
        r_n        <= n_n;
        r_cnt      <= n_cnt;
        r_lim      <= n_lim;
        r_rv       <= n_rv;
        r_ra       <= n_ra;
        r_fail     <= n_fail;
        r_k        <= n_k;
        r_best_vld <= n_best_vld;
        r_best_ord <= n_best_ord;
        r_best_pos <= n_best_pos;
        r_h        <= n_h;
        r_p        <= n_p;
        r_b        <= n_b;
        r_mid      <= n_mid;
        r_o        <= n_o;
        r_fk       <= n_fk;
        r_j        <= n_j;
        r_st       <= n_st;
        r_start    <= n_start;
        r_status   <= n_status;
    end

    assign o_ready         = (r_state == S_IDLE) && !i_cfg_we;
    assign o_ram_req       = w_req;
    assign o_result.vld    = (r_state == S_DONE);
    assign o_result.start  = r_start;
    assign o_result.status = r_status;
endmodule
